### hdl/sxl_pkg.sv
// sxl_pkg: types, character codes and helper functions of the s-expression lexer
// no dependencies; used by sxl_front, sxl_fifo, sxl_back, the top level and the bench
package sxl_pkg;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChBtick  = 8'h60;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChQmark  = 8'h3f;

  localparam int unsigned MaxEvents = 4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_ATOM,
    MODE_COMMA,
    MODE_STR,
    MODE_ESC
  } lex_mode_e;

  typedef enum logic [1:0] {
    EV_BEGIN = 2'd0,
    EV_CHAR  = 2'd1,
    EV_END   = 2'd2,
    EV_ERR   = 2'd3
  } event_e;

  typedef struct packed {
    event_e     ev;
    logic [7:0] ch;
    logic       text;
  } event_t;

  // events caused by one input item, in order
  typedef struct packed {
    logic [2:0]   cnt;
    event_t [3:0] evs;
  } cmd_t;

  function automatic cmd_t cmd_push(cmd_t c, event_e e, logic [7:0] ch, logic text);
    cmd_t r;
    r = c;
    r.evs[c.cnt[1:0]].ev   = e;
    r.evs[c.cnt[1:0]].ch   = ch;
    r.evs[c.cnt[1:0]].text = text;
    r.cnt = c.cnt + 3'd1;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  // zero means no table entry
  function automatic logic [7:0] escape_map(logic [7:0] c);
    logic [7:0] m;
    unique case (c)
      ChDquote: m = ChDquote;
      ChQuote:  m = ChQuote;
      ChQmark:  m = ChQmark;
      ChBslash: m = ChBslash;
      8'h61:    m = 8'd7;
      8'h62:    m = 8'd8;
      8'h66:    m = 8'd12;
      8'h6e:    m = 8'd10;
      8'h72:    m = 8'd13;
      8'h74:    m = 8'd9;
      8'h76:    m = 8'd11;
      default:  m = 8'd0;
    endcase
    return m;
  endfunction

endpackage

### hdl/sxl_if.sv
// sxl_in_if and sxl_out_if: valid/ready channels of the s-expression lexer
// no dependencies
interface sxl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sxl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] out_char;
  logic       is_text;
  logic       last;

  modport source (output valid, output event_res, output out_char, output is_text,
                  output last, input ready);
  modport sink (input valid, input event_res, input out_char, input is_text,
                input last, output ready);
endinterface

### hdl/sxl_front.sv
// sxl_front: accepts bytes, tracks the lexer mode and builds the event list of each item
// depends on sxl_pkg and sxl_in_if
module sxl_front import sxl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  sxl_in_if.sink   in_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  lex_mode_e  mode_q, mode_d;
  cmd_t       cmd;
  logic       run_idle;
  logic [7:0] c;
  logic [7:0] esc;
  logic       accept;

  assign c      = in_i.in_byte;
  assign esc    = escape_map(c);
  assign accept = in_i.valid && in_i.ready;

  assign in_i.ready = !full_i;
  assign push_o     = accept && (cmd.cnt != 3'd0);
  assign cmd_o      = cmd;

  always_comb begin
    cmd      = '0;
    mode_d   = mode_q;
    run_idle = 1'b0;
    if (in_i.end_of_input) begin
      mode_d = MODE_IDLE;
      if (mode_q == MODE_ATOM || mode_q == MODE_COMMA) begin
        cmd = cmd_push(cmd, EV_END, 8'd0, 1'b0);
      end else if (mode_q == MODE_STR || mode_q == MODE_ESC) begin
        cmd = cmd_push(cmd, EV_ERR, 8'd0, 1'b1);
      end
    end else begin
      unique case (mode_q)
        MODE_COMMENT: begin
          if (c == ChLf) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_ATOM: begin
          priority if (is_space(c)) begin
            cmd    = cmd_push(cmd, EV_END, 8'd0, 1'b0);
            mode_d = MODE_IDLE;
          end else if (c == ChLParen || c == ChRParen) begin
            cmd      = cmd_push(cmd, EV_END, 8'd0, 1'b0);
            run_idle = 1'b1;
          end else if (c == ChQuote || c == ChBtick) begin
            cmd    = cmd_push(cmd, EV_CHAR, c, 1'b0);
            cmd    = cmd_push(cmd, EV_END, 8'd0, 1'b0);
            mode_d = MODE_IDLE;
          end else if (c == ChComma) begin
            cmd    = cmd_push(cmd, EV_CHAR, c, 1'b0);
            mode_d = MODE_COMMA;
          end else begin
            cmd = cmd_push(cmd, EV_CHAR, c, 1'b0);
          end
        end
        MODE_COMMA: begin
          if (c == ChAt) begin
            cmd    = cmd_push(cmd, EV_CHAR, c, 1'b0);
            cmd    = cmd_push(cmd, EV_END, 8'd0, 1'b0);
            mode_d = MODE_IDLE;
          end else begin
            cmd      = cmd_push(cmd, EV_END, 8'd0, 1'b0);
            run_idle = 1'b1;
          end
        end
        MODE_STR: begin
          priority if (c == ChBslash) begin
            mode_d = MODE_ESC;
          end else if (c == ChDquote) begin
            cmd    = cmd_push(cmd, EV_END, 8'd0, 1'b1);
            mode_d = MODE_IDLE;
          end else begin
            cmd = cmd_push(cmd, EV_CHAR, c, 1'b1);
          end
        end
        MODE_ESC: begin
          if (esc != 8'd0) begin
            cmd = cmd_push(cmd, EV_CHAR, esc, 1'b1);
          end else begin
            cmd = cmd_push(cmd, EV_CHAR, ChBslash, 1'b1);
            cmd = cmd_push(cmd, EV_CHAR, c, 1'b1);
          end
          mode_d = MODE_STR;
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      // byte between tokens
      if (run_idle) begin
        priority if (is_space(c)) begin
          mode_d = MODE_IDLE;
        end else if (c == ChSemi) begin
          mode_d = MODE_COMMENT;
        end else if (c == ChLParen || c == ChRParen || c == ChQuote || c == ChBtick) begin
          cmd    = cmd_push(cmd, EV_BEGIN, 8'd0, 1'b0);
          cmd    = cmd_push(cmd, EV_CHAR, c, 1'b0);
          cmd    = cmd_push(cmd, EV_END, 8'd0, 1'b0);
          mode_d = MODE_IDLE;
        end else if (c == ChComma) begin
          cmd    = cmd_push(cmd, EV_BEGIN, 8'd0, 1'b0);
          cmd    = cmd_push(cmd, EV_CHAR, c, 1'b0);
          mode_d = MODE_COMMA;
        end else if (c == ChDquote) begin
          cmd    = cmd_push(cmd, EV_BEGIN, 8'd0, 1'b1);
          mode_d = MODE_STR;
        end else begin
          cmd    = cmd_push(cmd, EV_BEGIN, 8'd0, 1'b0);
          cmd    = cmd_push(cmd, EV_CHAR, c, 1'b0);
          mode_d = MODE_ATOM;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd.cnt <= 3'(MaxEvents))) else $error("too many events for one item");
  a_mode_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_ESC) else $error("lexer mode out of range");

endmodule

### hdl/sxl_fifo.sv
// sxl_fifo: two-entry queue of event lists between the front and back halves
// depends on sxl_pkg
module sxl_fifo import sxl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q)) else $error("queue pointers disagree");

endmodule

### hdl/sxl_back.sv
// sxl_back: delivers the events of the head list one per cycle while the output is ready and marks the last one
// depends on sxl_pkg and sxl_out_if
module sxl_back import sxl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  cmd_t     head_i,
  output logic     pop_o,
  sxl_out_if.source out_o
);

  logic [1:0] idx_q, idx_d;
  logic       is_last;
  logic       fire;
  event_t     cur;

  assign cur     = head_i.evs[idx_q];
  assign is_last = ({1'b0, idx_q} == (head_i.cnt - 3'd1));
  assign fire    = out_o.valid && out_o.ready;
  assign pop_o   = fire && is_last;

  assign out_o.valid     = !empty_i;
  assign out_o.event_res = cur.ev;
  assign out_o.out_char  = cur.ch;
  assign out_o.is_text   = cur.text;
  assign out_o.last      = is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, idx_q} < head_i.cnt)) else $error("event index past list end");
  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (head_i.cnt != 3'd0)) else $error("empty event list queued");
  a_idx_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0)) else $error("index not rewound after last event");

endmodule

### hdl/sexpr_token_lexer.sv
// sexpr_token_lexer: streaming tokenizer for lisp source text, top level
// depends on sxl_pkg, sxl_if, sxl_front, sxl_fifo and sxl_back
// the event list of an item is registered in the event queue before its first event is offered
// throughput: one item per cycle while the output is ready and each gives at most one event; an item giving
// n events (up to four) holds the output port, one event per cycle while the output is ready
// reset: lexer mode returns to idle between tokens and the event queue empties
module sexpr_token_lexer import sxl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sxl_in_if.sink    in_i,
  sxl_out_if.source out_o
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t cmd;
  cmd_t head;

  sxl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  sxl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  sxl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### bench/sexpr_token_lexer_tb.sv
// sexpr_token_lexer_tb: self-checking bench for the s-expression lexer, byte items in,
// token events out, each event checked against hand-written events or a behavioral lexer kept in the bench
// depends on sxl_pkg, sxl_if and the sexpr_token_lexer rtl
module sexpr_token_lexer_tb;
  import sxl_pkg::*;

  typedef struct packed {
    event_e     ev;
    logic [7:0] ch;
    logic       text;
    logic       last;
  } tok_ev_t;

  // one source item; typed rows carry their events written out by hand
  typedef struct packed {
    logic [7:0]    b;
    logic          eoi;
    logic          typed;
    logic [2:0]    n;
    tok_ev_t [0:3] evs;
  } src_item_t;

  localparam tok_ev_t NoEv        = '0;
  localparam int      HoldCycles  = 80;
  localparam int      RandomItems = 145;

  logic clk;
  logic rst_n;

  sxl_in_if  in_ch ();
  sxl_out_if out_ch ();

  sexpr_token_lexer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lex_mode_e lex_state = MODE_IDLE;
  tok_ev_t   step_evs [4];
  int        step_n;
  tok_ev_t   pending_events [$];
  src_item_t src_items [$];
  src_item_t in_row;
  int        err_cnt = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;

  logic [7:0] esc_keys [11] = '{ChDquote, ChQuote, ChQmark, ChBslash, 8'h61, 8'h62,
                                8'h66, 8'h6e, 8'h72, 8'h74, 8'h76};

  function automatic tok_ev_t tv(event_e e, logic [7:0] c, logic t, logic l);
    tok_ev_t r;
    r.ev = e;
    r.ch = c;
    r.text = t;
    r.last = l;
    return r;
  endfunction

  function automatic src_item_t plain(logic [7:0] b, logic eoi);
    src_item_t r;
    r = '0;
    r.b = b;
    r.eoi = eoi;
    return r;
  endfunction

  function automatic src_item_t known(logic [7:0] b, logic eoi, logic [2:0] n,
                                      tok_ev_t e0, tok_ev_t e1, tok_ev_t e2);
    src_item_t r;
    r = plain(b, eoi);
    r.typed = 1'b1;
    r.n = n;
    r.evs[0] = e0;
    r.evs[1] = e1;
    r.evs[2] = e2;
    return r;
  endfunction

  function automatic void add_item(src_item_t it);
    src_items.insert(src_items.size(), it);
  endfunction

  function automatic void add_event(tok_ev_t e);
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  // zero means the byte is not in the escape table
  function automatic logic [7:0] unescape(logic [7:0] c);
    case (c)
      ChDquote, ChQuote, ChQmark, ChBslash: return c;
      8'h61: return 8'd7;
      8'h62: return 8'd8;
      8'h66: return 8'd12;
      8'h6e: return 8'd10;
      8'h72: return 8'd13;
      8'h74: return 8'd9;
      8'h76: return 8'd11;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChCr;
      default: return ChLf;
    endcase
  endfunction

  function void emit_ev(event_e e, logic [7:0] c, logic t);
    step_evs[step_n] = tv(e, c, t, 1'b0);
    step_n++;
  endfunction

  function void start_token(logic [7:0] c);
    if (is_blank(c)) begin
      lex_state = MODE_IDLE;
    end else if (c == ChSemi) begin
      lex_state = MODE_COMMENT;
    end else if (c == ChLParen || c == ChRParen || c == ChQuote || c == ChBtick) begin
      emit_ev(EV_BEGIN, 8'h00, 1'b0);
      emit_ev(EV_CHAR, c, 1'b0);
      emit_ev(EV_END, 8'h00, 1'b0);
      lex_state = MODE_IDLE;
    end else if (c == ChComma) begin
      emit_ev(EV_BEGIN, 8'h00, 1'b0);
      emit_ev(EV_CHAR, c, 1'b0);
      lex_state = MODE_COMMA;
    end else if (c == ChDquote) begin
      emit_ev(EV_BEGIN, 8'h00, 1'b1);
      lex_state = MODE_STR;
    end else begin
      emit_ev(EV_BEGIN, 8'h00, 1'b0);
      emit_ev(EV_CHAR, c, 1'b0);
      lex_state = MODE_ATOM;
    end
  endfunction

  // events caused by one item, left in step_evs and step_n
  function void lex_step(logic [7:0] c, logic eoi);
    logic [7:0] m;
    step_n = 0;
    if (eoi) begin
      case (lex_state)
        MODE_ATOM, MODE_COMMA: emit_ev(EV_END, 8'h00, 1'b0);
        MODE_STR, MODE_ESC: emit_ev(EV_ERR, 8'h00, 1'b1);
        default: ;
      endcase
      lex_state = MODE_IDLE;
    end else begin
      case (lex_state)
        MODE_COMMENT: begin
          if (c == ChLf) lex_state = MODE_IDLE;
        end
        MODE_ATOM: begin
          if (is_blank(c)) begin
            emit_ev(EV_END, 8'h00, 1'b0);
            lex_state = MODE_IDLE;
          end else if (c == ChLParen || c == ChRParen) begin
            emit_ev(EV_END, 8'h00, 1'b0);
            start_token(c);
          end else if (c == ChQuote || c == ChBtick) begin
            emit_ev(EV_CHAR, c, 1'b0);
            emit_ev(EV_END, 8'h00, 1'b0);
            lex_state = MODE_IDLE;
          end else if (c == ChComma) begin
            emit_ev(EV_CHAR, c, 1'b0);
            lex_state = MODE_COMMA;
          end else begin
            emit_ev(EV_CHAR, c, 1'b0);
          end
        end
        MODE_COMMA: begin
          if (c == ChAt) begin
            emit_ev(EV_CHAR, c, 1'b0);
            emit_ev(EV_END, 8'h00, 1'b0);
            lex_state = MODE_IDLE;
          end else begin
            emit_ev(EV_END, 8'h00, 1'b0);
            start_token(c);
          end
        end
        MODE_STR: begin
          if (c == ChBslash) begin
            lex_state = MODE_ESC;
          end else if (c == ChDquote) begin
            emit_ev(EV_END, 8'h00, 1'b1);
            lex_state = MODE_IDLE;
          end else begin
            emit_ev(EV_CHAR, c, 1'b1);
          end
        end
        MODE_ESC: begin
          m = unescape(c);
          if (m != 8'd0) begin
            emit_ev(EV_CHAR, m, 1'b1);
          end else begin
            emit_ev(EV_CHAR, ChBslash, 1'b1);
            emit_ev(EV_CHAR, c, 1'b1);
          end
          lex_state = MODE_STR;
        end
        default: start_token(c);
      endcase
    end
    if (step_n > 0) step_evs[step_n - 1].last = 1'b1;
  endfunction

  function void check_field(string what, int want, int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // mostly well-formed tokens with random content, some noise and broken ones
  task automatic fill_random();
    int len;
    int r;
    logic [7:0] c;
    while (src_items.size() < 25 + RandomItems) begin
      r = $urandom_range(99);
      if (r < 15) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) add_item(plain(8'($urandom_range(255)), 1'b0));
      end else if (r < 40) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          c = 8'($urandom_range(33, 126));
          if (c inside {ChLParen, ChRParen, ChQuote, ChBtick, ChComma} ||
              (k == 0 && c inside {ChSemi, ChDquote})) c = 8'(8'h41 + k);
          if ($urandom_range(9) == 0) c = 8'($urandom_range(128, 255));
          add_item(plain(c, 1'b0));
        end
        case ($urandom_range(9))
          0, 1, 2, 3: add_item(plain(pick_blank(), 1'b0));
          4: add_item(plain($urandom_range(1) ? ChLParen : ChRParen, 1'b0));
          5: add_item(plain($urandom_range(1) ? ChQuote : ChBtick, 1'b0));
          6: begin
            add_item(plain(ChComma, 1'b0));
            if ($urandom_range(1)) add_item(plain(ChAt, 1'b0));
          end
          7: add_item(plain(8'($urandom_range(255)), 1'b1));
          default: ;
        endcase
      end else if (r < 60) begin
        add_item(plain(ChDquote, 1'b0));
        len = $urandom_range(0, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) < 3) begin
            add_item(plain(ChBslash, 1'b0));
            c = $urandom_range(1) ? esc_keys[4'($urandom_range(10))]
                                  : 8'($urandom_range(255));
          end else begin
            c = 8'($urandom_range(255));
            if (c == ChDquote || c == ChBslash) c = 8'h41;
          end
          add_item(plain(c, 1'b0));
        end
        if ($urandom_range(9) == 0) add_item(plain(8'($urandom_range(255)), 1'b1));
        else add_item(plain(ChDquote, 1'b0));
      end else if (r < 68) begin
        add_item(plain(ChSemi, 1'b0));
        len = $urandom_range(0, 5);
        for (int k = 0; k < len; k++) begin
          c = 8'($urandom_range(255));
          if (c == ChLf) c = 8'h2e;
          add_item(plain(c, 1'b0));
        end
        add_item(plain(ChLf, 1'b0));
      end else if (r < 84) begin
        case ($urandom_range(5))
          0: add_item(plain(ChLParen, 1'b0));
          1: add_item(plain(ChRParen, 1'b0));
          2: add_item(plain(ChQuote, 1'b0));
          3: add_item(plain(ChBtick, 1'b0));
          4: add_item(plain(ChComma, 1'b0));
          default: begin
            add_item(plain(ChComma, 1'b0));
            add_item(plain(ChAt, 1'b0));
          end
        endcase
      end else if (r < 93) begin
        add_item(plain(pick_blank(), 1'b0));
      end else begin
        add_item(plain(8'($urandom_range(255)), 1'b1));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : drain
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin : watch
    tok_ev_t want;
    tok_ev_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        lex_step(in_ch.in_byte, in_ch.end_of_input);
        if (in_row.typed) begin
          for (int k = 0; k < in_row.n; k++) add_event(in_row.evs[k]);
        end else begin
          for (int k = 0; k < step_n; k++) add_event(step_evs[k]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = tv(event_e'(out_ch.event_res), out_ch.out_char, out_ch.is_text, out_ch.last);
        if (pending_events.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected event, expected none, got %0h", $time, got);
        end else begin
          want = pending_events.pop_front();
          check_field("event_res", want.ev, got.ev);
          check_field("out_char", want.ch, got.ch);
          check_field("is_text", want.text, got.text);
          check_field("last", want.last, got.last);
        end
      end
    end
  end

  initial begin : feed
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    in_row <= '0;

    // end of input right after reset, extremes, every token kind, escapes, error
    add_item(known(8'h00, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    add_item(known(ChLParen, 1'b0, 3'd3, tv(EV_BEGIN, 8'h00, 1'b0, 1'b0),
                   tv(EV_CHAR, ChLParen, 1'b0, 1'b0),
                   tv(EV_END, 8'h00, 1'b0, 1'b1)));
    add_item(known(8'h00, 1'b0, 3'd2, tv(EV_BEGIN, 8'h00, 1'b0, 1'b0),
                   tv(EV_CHAR, 8'h00, 1'b0, 1'b1), NoEv));
    add_item(plain(ChSemi, 1'b0));
    add_item(plain(ChDquote, 1'b0));
    add_item(plain(8'hff, 1'b0));
    add_item(plain(ChComma, 1'b0));
    add_item(plain(ChAt, 1'b0));
    add_item(plain(ChSpace, 1'b0));
    add_item(known(ChComma, 1'b0, 3'd2, tv(EV_BEGIN, 8'h00, 1'b0, 1'b0),
                   tv(EV_CHAR, ChComma, 1'b0, 1'b1), NoEv));
    add_item(plain(ChRParen, 1'b0));
    add_item(plain(ChBtick, 1'b0));
    add_item(plain(8'h78, 1'b0));
    add_item(plain(ChQuote, 1'b0));
    add_item(plain(ChSemi, 1'b0));
    add_item(plain(ChLParen, 1'b0));
    add_item(plain(ChLf, 1'b0));
    add_item(plain(ChDquote, 1'b0));
    add_item(plain(ChDquote, 1'b0));
    add_item(plain(ChDquote, 1'b0));
    add_item(plain(ChBslash, 1'b0));
    add_item(plain(8'h76, 1'b0));
    add_item(plain(ChBslash, 1'b0));
    add_item(plain(8'hff, 1'b0));
    add_item(known(8'hff, 1'b1, 3'd1, tv(EV_ERR, 8'h00, 1'b1, 1'b1), NoEv, NoEv));
    fill_random();

    while (!rst_n) @(posedge clk);
    @(posedge clk);

    for (int i = 0; i < src_items.size(); i++) begin
      calm = (i >= 90 && i < 130);
      if (i == 60) hold_req = 1'b1;
      if (i == 25 || i == 150) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      while (!calm && $urandom_range(99) < 32) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.in_byte <= src_items[i].b;
      in_ch.end_of_input <= src_items[i].eoi;
      in_row <= src_items[i];
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
